// ===== rtl/lwma_pkg.sv =====
// Package for the linear weighted moving average block.
// Widths, window constants, job record and state types; no dependencies.
package lwma_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = 6;
    localparam int SAMPLE_W    = 16;
    localparam int WSUM_W      = 26;
    localparam int PSUM_W      = 22;
    localparam int DEN_W       = 10;
    localparam int PROD_W      = SAMPLE_W + CNT_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] LEN_AT_RESET = CNT_W'(20);
    localparam logic [CNT_W-1:0] LEN_MAX      = CNT_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] LEN_MIN      = CNT_W'(1);

    // Work handed from the window front end to the divider.
    typedef struct packed {
        logic signed [WSUM_W-1:0] wsum;
        logic [DEN_W-1:0]         denom;
        logic [CNT_W-1:0]         fill_count;
        logic                     window_full;
    } t_job;

    typedef enum logic {
        FS_IDLE,
        FS_CALC
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_DONE
    } t_back_state;

endpackage

// ===== rtl/lwma_in_if.sv =====
// Input channel: one signed sample per transaction.
// Depends on lwma_pkg.
interface lwma_in_if import lwma_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/lwma_out_if.sv =====
// Output channel: weighted mean, fill count and full flag per transaction.
// Depends on lwma_pkg.
interface lwma_out_if import lwma_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] weighted_mean;
    logic [CNT_W-1:0]           fill_count;
    logic                       window_full;

    modport source (output valid, output weighted_mean, output fill_count,
                    output window_full, input ready);
    modport sink   (input valid, input weighted_mean, input fill_count,
                    input window_full, output ready);
endinterface

// ===== rtl/lwma_front.sv =====
// Front end: window length register, sample store, running sums.
// Accepts samples and pushes division jobs. Depends on lwma_pkg, lwma_in_if.
module lwma_front import lwma_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    lwma_in_if.sink          i_in,
    input  logic             i_push_ready,
    output logic             o_push_valid,
    output t_job             o_push_job
);

    t_front_state r_state, n_state;

    logic [CNT_W-1:0]           r_window_length;
    logic [CNT_W-1:0]           r_held;
    logic [PTR_W-1:0]           r_oldest_ptr;
    logic signed [WSUM_W-1:0]   r_wsum;
    logic signed [PSUM_W-1:0]   r_psum;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_old_sample;
    logic signed [SAMPLE_W-1:0] r_store [MAX_WINDOW];

    logic                       accept;
    logic [CNT_W-1:0]           eff_len;
    logic                       drop;
    logic [CNT_W-1:0]           held_base;
    logic [CNT_W-1:0]           held_new;
    logic [PTR_W-1:0]           wr_idx;
    logic [PTR_W-1:0]           ptr_new;
    logic signed [PROD_W-1:0]   prod;
    logic signed [WSUM_W-1:0]   wsum_base;
    logic signed [WSUM_W-1:0]   wsum_new;
    logic signed [PSUM_W-1:0]   psum_new;
    logic [2*CNT_W:0]           den_prod;

    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        if (r_window_length == '0) begin
            eff_len = LEN_MIN;
        end else if (r_window_length > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_window_length;
        end
    end

    // Window update, done in the cycle after the old sample is read.
    // New sample lands just past the newest held one, counted from the
    // oldest pointer after the drop.
    always_comb begin
        drop      = (r_held >= eff_len) && (r_held != '0);
        held_base = drop ? (r_held - CNT_W'(1)) : r_held;
        held_new  = held_base + CNT_W'(1);
        ptr_new   = drop ? (r_oldest_ptr + PTR_W'(1)) : r_oldest_ptr;
        wr_idx    = ptr_new + held_base[PTR_W-1:0];
        prod      = $signed({1'b0, held_new}) * r_sample;
        wsum_base = drop ? (r_wsum - WSUM_W'(r_psum)) : r_wsum;
        wsum_new  = wsum_base + WSUM_W'(prod);
        psum_new  = r_psum + PSUM_W'(r_sample)
                  - (drop ? PSUM_W'(r_old_sample) : PSUM_W'(0));
        den_prod  = (2*CNT_W+1)'(held_new) * (2*CNT_W+1)'(held_new + CNT_W'(1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) n_state = FS_CALC;
            end
            FS_CALC: begin
                n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready   = 1'b0;
        o_push_valid = 1'b0;
        unique case (r_state)
            FS_IDLE: i_in.ready   = i_push_ready;
            FS_CALC: o_push_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_push_job.wsum        = wsum_new;
    assign o_push_job.denom       = den_prod[DEN_W:1];
    assign o_push_job.fill_count  = held_new;
    assign o_push_job.window_full = (held_new == eff_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= FS_IDLE;
            r_window_length <= LEN_AT_RESET;
            r_held          <= '0;
            r_oldest_ptr    <= '0;
            r_wsum          <= '0;
            r_psum          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window_length <= i_cfg_wdata;
                r_held          <= '0;
                r_oldest_ptr    <= '0;
                r_wsum          <= '0;
                r_psum          <= '0;
            end else if (r_state == FS_CALC) begin
                r_held       <= held_new;
                r_oldest_ptr <= ptr_new;
                r_wsum       <= wsum_new;
                r_psum       <= psum_new;
            end
        end
    end

    // Sample store: read oldest on accept, write new sample in the calc cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample     <= i_in.sample;
            r_old_sample <= r_store[r_oldest_ptr];
        end
        if (r_state == FS_CALC) begin
            r_store[wr_idx] <= r_sample;
        end
    end

endmodule

// ===== rtl/lwma_queue.sv =====
// Short job queue between the window front end and the divider.
// Depends on lwma_pkg.
module lwma_queue import lwma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop_ready
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (push && !pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push_job;
    end

endmodule

// ===== rtl/lwma_back.sv =====
// Back end: restoring divider, one quotient bit per cycle, and output register.
// Depends on lwma_pkg, lwma_out_if.
module lwma_back import lwma_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    input  t_job       i_pop_job,
    output logic       o_pop_ready,
    lwma_out_if.source o_out
);

    localparam int STEP_W = $clog2(WSUM_W);

    t_back_state r_state, n_state;

    logic [WSUM_W-1:0]          r_quo;
    logic [DEN_W-1:0]           r_rem;
    logic [DEN_W-1:0]           r_div;
    logic [STEP_W-1:0]          r_step;
    logic                       r_neg;
    logic [CNT_W-1:0]           r_fill;
    logic                       r_full;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [CNT_W-1:0]           r_out_fill;
    logic                       r_out_full;

    logic                       load_out;
    logic                       last_step;
    logic [DEN_W:0]             rem_sh;
    logic [DEN_W:0]             rem_diff;
    logic                       q_bit;
    logic [WSUM_W-1:0]          quo_signed;

    assign last_step = (r_step == STEP_W'(WSUM_W - 1));
    assign load_out  = !r_out_valid || o_out.ready;

    always_comb begin
        rem_sh     = {r_rem, r_quo[WSUM_W-1]};
        rem_diff   = rem_sh - {1'b0, r_div};
        q_bit      = (rem_sh >= {1'b0, r_div});
        quo_signed = r_neg ? (~r_quo + WSUM_W'(1)) : r_quo;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_pop_valid) n_state = BS_DIV;
            end
            BS_DIV: begin
                if (last_step) n_state = BS_DONE;
            end
            BS_DONE: begin
                if (load_out) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready = 1'b0;
        unique case (r_state)
            BS_IDLE: o_pop_ready = 1'b1;
            BS_DIV,
            BS_DONE: o_pop_ready = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_DONE && load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divide magnitude, fix the sign at the end: truncation toward zero.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                r_neg  <= i_pop_job.wsum[WSUM_W-1];
                r_quo  <= i_pop_job.wsum[WSUM_W-1] ? (~i_pop_job.wsum + WSUM_W'(1))
                                                    : i_pop_job.wsum;
                r_rem  <= '0;
                r_div  <= i_pop_job.denom;
                r_step <= '0;
                r_fill <= i_pop_job.fill_count;
                r_full <= i_pop_job.window_full;
            end
            BS_DIV: begin
                r_rem  <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo  <= {r_quo[WSUM_W-2:0], q_bit};
                r_step <= r_step + STEP_W'(1);
            end
            BS_DONE: begin
                if (load_out) begin
                    r_mean     <= $signed(quo_signed[SAMPLE_W-1:0]);
                    r_out_fill <= r_fill;
                    r_out_full <= r_full;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.weighted_mean = r_mean;
    assign o_out.fill_count    = r_out_fill;
    assign o_out.window_full   = r_out_full;

endmodule

// ===== rtl/linear_weighted_moving_average.sv =====
// Linear weighted moving average over up to 32 signed 16-bit samples.
// Path: the front end (accept, then calc) pushes a job into the queue; the back end
// loads it, runs the 26-step restoring divider, then registers the result. The back
// end takes one job at a time, and the front end takes a new sample only after
// pushing the job for the last one.
// Reset (synchronous, active low): window empty, window length 20, queue and
// output register empty. The sample store is not cleared; empty slots are never read.
module linear_weighted_moving_average import lwma_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    lwma_in_if.sink          i_in,
    lwma_out_if.source       o_out
);

    // Front end -> queue
    logic push_valid;
    logic push_ready;
    t_job push_job;

    // Queue -> divider
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    // Front end owns the window: it reads the oldest sample on accept, then
    // in the next cycle drops it (if the window is full), writes the new one
    // and forms the weighted sum and the denominator n(n+1)/2. It only takes
    // a transaction while the queue has room, so the push never stalls.
    lwma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_job   (push_job)
    );

    // Jobs wait here while the divider is busy, so the front end keeps
    // accepting samples during a division until the queue is full.
    lwma_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop_ready  (pop_ready)
    );

    // Back end divides one job at a time and holds the result in an output
    // register until the sink takes the transaction.
    lwma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_job   (pop_job),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule
